>>> hw/rtl/rqs_pkg.sv
`default_nettype none

package rqs_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int ID_WIDTH    = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int PRI_W       = 7;
  localparam int RND_W       = 31;
  localparam int MODE_W      = 2;
  localparam int AGE_W       = 16;
  localparam int SCNT_W      = 17;
  localparam int STAT_W      = 2;
  localparam int MOD_CNT_W   = $clog2(RND_W);

  // Stream packing
  localparam int IN_FIELDS_W  = ID_WIDTH + PRI_W + RND_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ID_WIDTH + PRI_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_PRI   = 2'd2;

  localparam logic [AGE_W-1:0] AGING_LIMIT_RST = 16'd2000;
  localparam logic [PRI_W-1:0] BOOST_PRI_RST   = 7'd50;

  // Codes
  localparam logic [MODE_W-1:0] MODE_FIFO     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RANDOM   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRIORITY = 2'd2;

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_SCHEDULE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_PICKED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Modulo unit handshake
  typedef struct packed {
    logic             start;
    logic [RND_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [PTR_W-1:0] rem;
  } mod_rsp_t;

  // Ring pointer plus offset (offset no larger than the depth)
  function automatic logic [PTR_W-1:0] add_wrap(input logic [PTR_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return PTR_W'(s);
  endfunction

  function automatic logic [PTR_W-1:0] inc_wrap(input logic [PTR_W-1:0] a);
    return add_wrap(a, CNT_W'(1));
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rqs_ram.sv
`default_nettype none

module rqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/rqs_mod.sv
`default_nettype none

module rqs_mod
  import rqs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mod_req_t req,
  output mod_rsp_t      rsp
);

  // Restoring remainder, one dividend bit a cycle
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MOD_CNT_W-1:0] bit_r, bit_nxt;
  logic [RND_W-1:0]     dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W:0]       trial;

  assign trial = {rem_r, dvd_r[RND_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      bit_nxt  = MOD_CNT_W'(RND_W - 1);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = CNT_W'(trial);
      end
      dvd_nxt = {dvd_r[RND_W-2:0], 1'b0};
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = PTR_W'(rem_r);

endmodule

`default_nettype wire

>>> hw/rtl/run_queue_priority_scheduler.sv
`default_nettype none

// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid / in_tready   tuser: opcode; tdata: task id, priority, draw
// out_     master     out_tvalid / out_tready tuser: status; tdata: picked id, priority
// cfg_     write      cfg_we                  cfg_index, cfg_data
//
// One item is in flight at a time; the next is taken while a result waits in the output
// register. Enqueue, empty and full answers pass through the result state. A FIFO pick
// rotates at once; a random pick first waits for the remainder unit, a priority pick first
// scans every entry of the queue, and when aging fires every entry is first boosted and
// the head is taken; entries that lie in front of the chosen one move to the tail first.
// Each memory's single read port sets the one-entry-a-cycle pace of scan and rotation.
// Reset is synchronous and clears head, fill and schedule counts, not the queue memories;
// configuration returns to defaults. A stalled output holds the finished pick until taken.

module run_queue_priority_scheduler
  import rqs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input items
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // task_id, task_priority, random_value
  input  wire logic                  in_tuser,   // opcode
  // results
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // picked_task, picked_priority
  output logic      [STAT_W-1:0]     out_tuser,  // status
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_BOOST,
    S_ROT,
    S_PICK,
    S_RES
  } state_t;

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SCNT_W-1:0]   sched_cnt_r, sched_cnt_nxt;
  logic [PTR_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    rcv_r, rcv_nxt;
  logic                pend_r, pend_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PRI_W-1:0]    best_r, best_nxt;
  status_t             stat_r, stat_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  status_t             out_tuser_r, out_tuser_nxt;

  logic [MODE_W-1:0]   mode_r;
  logic [AGE_W-1:0]    age_lim_r;
  logic [PRI_W-1:0]    boost_r;

  logic                mem_we_id, mem_we_pri;
  logic [PTR_W-1:0]    mem_waddr;
  logic [ID_WIDTH-1:0] mem_wid, id_rdata;
  logic [PRI_W-1:0]    mem_wpri, pri_rdata;

  mod_req_t            mod_req;
  mod_rsp_t            mod_rsp;

  logic [ID_WIDTH-1:0] in_id;
  logic [PRI_W-1:0]    in_pri;
  logic [RND_W-1:0]    in_rnd;
  logic                in_acc, out_free, go_rot;
  logic [PTR_W-1:0]    tail;
  logic [SCNT_W-1:0]   cnt_inc;

  assign in_id    = in_tdata[ID_WIDTH-1:0];
  assign in_pri   = in_tdata[ID_WIDTH +: PRI_W];
  assign in_rnd   = in_tdata[ID_WIDTH+PRI_W +: RND_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign tail     = add_wrap(head_r, count_r);
  assign cnt_inc  = sched_cnt_r + 1'b1;

  rqs_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_id_ram (
    .clk   (clk),
    .we    (mem_we_id),
    .waddr (mem_waddr),
    .wdata (mem_wid),
    .raddr (rd_ptr_r),
    .rdata (id_rdata)
  );

  rqs_ram #(.WIDTH(PRI_W), .DEPTH(QUEUE_DEPTH)) u_pri_ram (
    .clk   (clk),
    .we    (mem_we_pri),
    .waddr (mem_waddr),
    .wdata (mem_wpri),
    .raddr (rd_ptr_r),
    .rdata (pri_rdata)
  );

  rqs_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    sched_cnt_nxt  = sched_cnt_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    rcv_nxt        = rcv_r;
    pend_nxt       = pend_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    best_nxt       = best_r;
    stat_nxt       = stat_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    go_rot         = 1'b0;

    // Default write path copies the entry just read (rotation)
    mem_we_id  = 1'b0;
    mem_we_pri = 1'b0;
    mem_waddr  = wr_ptr_r;
    mem_wid    = id_rdata;
    mem_wpri   = pri_rdata;

    mod_req.start    = 1'b0;
    mod_req.dividend = in_rnd;
    mod_req.divisor  = count_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_ENQUEUE) begin
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              stat_nxt = ST_FULL;
            end else begin
              // Append at the tail
              mem_we_id  = 1'b1;
              mem_we_pri = 1'b1;
              mem_waddr  = tail;
              mem_wid    = in_id;
              mem_wpri   = in_pri;
              count_nxt  = count_r + 1'b1;
              stat_nxt   = ST_ENQUEUED;
            end
            state_nxt = S_RES;
          end else if (count_r == '0) begin
            stat_nxt  = ST_EMPTY;
            state_nxt = S_RES;
          end else begin
            case (mode_r)
              MODE_RANDOM: begin
                mod_req.start = 1'b1;
                state_nxt     = S_MOD;
              end
              MODE_PRIORITY: begin
                if (cnt_inc > SCNT_W'(age_lim_r)) begin
                  // Aging fires: boost every entry, then take the head
                  sched_cnt_nxt = '0;
                  wr_ptr_nxt    = head_r;
                  idx_nxt       = '0;
                  state_nxt     = S_BOOST;
                end else begin
                  sched_cnt_nxt = cnt_inc;
                  rd_ptr_nxt    = head_r;
                  idx_nxt       = '0;
                  rcv_nxt       = '0;
                  pend_nxt      = 1'b0;
                  state_nxt     = S_SCAN;
                end
              end
              default: begin
                k_nxt  = '0;
                go_rot = 1'b1;
              end
            endcase
          end
        end
      end

      S_MOD: begin
        if (mod_rsp.done) begin
          k_nxt  = mod_rsp.rem;
          go_rot = 1'b1;
        end
      end

      S_SCAN: begin
        // Issue one read a cycle, compare each entry as the registered memory read returns it
        pend_nxt = 1'b0;
        if (idx_r < count_r) begin
          rd_ptr_nxt = inc_wrap(rd_ptr_r);
          idx_nxt    = idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end
        if (pend_r) begin
          rcv_nxt = rcv_r + 1'b1;
          // Strict greater keeps the first of equal priorities
          if (rcv_r == '0 || pri_rdata > best_r) begin
            best_nxt = pri_rdata;
            k_nxt    = PTR_W'(rcv_r);
          end
          if (rcv_r == count_r - 1'b1) begin
            go_rot = 1'b1;
          end
        end
      end

      S_BOOST: begin
        mem_we_pri = 1'b1;
        mem_wpri   = boost_r;
        wr_ptr_nxt = inc_wrap(wr_ptr_r);
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == count_r - 1'b1) begin
          k_nxt  = '0;
          go_rot = 1'b1;
        end
      end

      S_ROT: begin
        // Move the k entries ahead of the chosen one from head to tail
        pend_nxt = 1'b0;
        if (idx_r != CNT_W'(k_r)) begin
          rd_ptr_nxt = inc_wrap(rd_ptr_r);
          idx_nxt    = idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end
        if (pend_r) begin
          mem_we_id  = 1'b1;
          mem_we_pri = 1'b1;
          wr_ptr_nxt = inc_wrap(wr_ptr_r);
        end
        // Read pointer now rests on the chosen entry
        if (idx_r == CNT_W'(k_r) && !pend_r) begin
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = ST_PICKED;
          out_tdata_nxt  = OUT_DATA_W'({pri_rdata, id_rdata});
          head_nxt       = inc_wrap(rd_ptr_r);
          count_nxt      = count_r - 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_RES: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = stat_r;
          out_tdata_nxt  = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_rot) begin
      rd_ptr_nxt = head_r;
      wr_ptr_nxt = tail;
      idx_nxt    = '0;
      pend_nxt   = 1'b0;
      state_nxt  = S_ROT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      sched_cnt_r  <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      mode_r       <= MODE_FIFO;
      age_lim_r    <= AGING_LIMIT_RST;
      boost_r      <= BOOST_PRI_RST;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      sched_cnt_r  <= sched_cnt_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCHED_MODE:  mode_r    <= cfg_data[MODE_W-1:0];
          CFG_AGING_LIMIT: age_lim_r <= cfg_data[AGE_W-1:0];
          CFG_BOOST_PRI:   boost_r   <= cfg_data[PRI_W-1:0];
          default: ;
        endcase
      end
    end
    k_r         <= k_nxt;
    idx_r       <= idx_nxt;
    rcv_r       <= rcv_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    wr_ptr_r    <= wr_ptr_nxt;
    best_r      <= best_nxt;
    stat_r      <= stat_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire
